### src/lfps_pkg.sv
// Shared widths, register indexes and reset values for the line-follow steering core.
package lfps_pkg;

   // Field and state widths
   localparam int SAMPLE_BITS    = 10;
   localparam int SPEED_BITS     = 8;
   localparam int TURN_BITS      = 8;
   localparam int GAIN_BITS      = 24;
   localparam int GAIN_FRAC_BITS = 16;
   localparam int SUM_BITS       = 24;
   localparam int ERR_BITS       = SAMPLE_BITS + 1;
   localparam int DIFF_BITS      = ERR_BITS + 1;
   localparam int CSR_IDX_BITS   = 2;

   // Product widths: unsigned gain (zero-extended) times signed operand
   localparam int PTERM_BITS = GAIN_BITS + ERR_BITS;
   localparam int ITERM_BITS = GAIN_BITS + SUM_BITS;
   localparam int DTERM_BITS = GAIN_BITS + DIFF_BITS;
   // Room for the three-term sum without overflow
   localparam int TOTAL_BITS = ITERM_BITS + 2;
   localparam int QUOT_BITS  = TOTAL_BITS - GAIN_FRAC_BITS;

   localparam logic [TURN_BITS-1:0] TURN_LIMIT = TURN_BITS'(100);

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRAY_LEVEL = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_P_GAIN     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_I_GAIN     = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_D_GAIN     = 2'd3;

   // Register reset values
   localparam logic [SAMPLE_BITS-1:0] GRAY_LEVEL_RST = SAMPLE_BITS'(550);
   localparam logic [GAIN_BITS-1:0]   P_GAIN_RST     = GAIN_BITS'(111411);
   localparam logic [GAIN_BITS-1:0]   I_GAIN_RST     = GAIN_BITS'(85);
   localparam logic [GAIN_BITS-1:0]   D_GAIN_RST     = GAIN_BITS'(1310720);

   typedef struct packed {
      logic [GAIN_BITS-1:0] p_gain;
      logic [GAIN_BITS-1:0] i_gain;
      logic [GAIN_BITS-1:0] d_gain;
   } gains_type;

endpackage

### src/lfps_err_stage.sv
// Error formation, saturating error sum and derivative difference; holds the loop state.
module lfps_err_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [lfps_pkg::SAMPLE_BITS-1:0]      gray_level,
   input  logic [lfps_pkg::SAMPLE_BITS-1:0]      light_sample,
   input  logic signed [lfps_pkg::SPEED_BITS-1:0] travel_speed,
   input  logic                                  clear_state,
   output logic signed [lfps_pkg::ERR_BITS-1:0]  err,
   output logic signed [lfps_pkg::SUM_BITS-1:0]  err_sum,
   output logic signed [lfps_pkg::DIFF_BITS-1:0] err_diff,
   output logic signed [lfps_pkg::SPEED_BITS-1:0] speed
);
   import lfps_pkg::*;

   logic signed [ERR_BITS-1:0]   err_ff, err_in, prev_eff;
   logic signed [SUM_BITS-1:0]   sum_ff, sum_in, sum_eff;
   logic signed [SUM_BITS:0]     acc;
   logic signed [DIFF_BITS-1:0]  diff_ff, diff_in;
   logic signed [SPEED_BITS-1:0] speed_ff;
   logic                         moving_fwd;

   // Error direction follows the sign of the speed; zero counts as reverse
   always_comb begin
      moving_fwd = !travel_speed[SPEED_BITS-1] && (travel_speed != '0);
      if (moving_fwd) begin
         err_in = $signed({1'b0, gray_level}) - $signed({1'b0, light_sample});
      end else begin
         err_in = $signed({1'b0, light_sample}) - $signed({1'b0, gray_level});
      end
   end

   // Clear acts before the step; sum saturates at the signed limits
   always_comb begin
      prev_eff = clear_state ? '0 : err_ff;
      sum_eff  = clear_state ? '0 : sum_ff;
      acc      = (SUM_BITS+1)'(sum_eff) + (SUM_BITS+1)'(err_in);
      if (acc[SUM_BITS] != acc[SUM_BITS-1]) begin
         sum_in = acc[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         sum_in = acc[SUM_BITS-1:0];
      end
      diff_in = DIFF_BITS'(err_in) - DIFF_BITS'(prev_eff);
   end

   // Error register doubles as the previous error, sum register as the error sum
   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= '0;
         sum_ff <= '0;
      end else if (accept) begin
         err_ff <= err_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         diff_ff  <= diff_in;
         speed_ff <= travel_speed;
      end
   end

   assign err      = err_ff;
   assign err_sum  = sum_ff;
   assign err_diff = diff_ff;
   assign speed    = speed_ff;

endmodule

### src/lfps_mult_stage.sv
// Registered P, I and D products.
module lfps_mult_stage (
   input  logic                                    clock,
   input  logic                                    enable,
   input  lfps_pkg::gains_type                     gains,
   input  logic signed [lfps_pkg::ERR_BITS-1:0]    err,
   input  logic signed [lfps_pkg::SUM_BITS-1:0]    err_sum,
   input  logic signed [lfps_pkg::DIFF_BITS-1:0]   err_diff,
   input  logic signed [lfps_pkg::SPEED_BITS-1:0]  speed,
   output logic signed [lfps_pkg::PTERM_BITS-1:0]  pterm,
   output logic signed [lfps_pkg::ITERM_BITS-1:0]  iterm,
   output logic signed [lfps_pkg::DTERM_BITS-1:0]  dterm,
   output logic signed [lfps_pkg::SPEED_BITS-1:0]  speed_out
);
   import lfps_pkg::*;

   logic signed [PTERM_BITS-1:0] pterm_ff, pterm_in;
   logic signed [ITERM_BITS-1:0] iterm_ff, iterm_in;
   logic signed [DTERM_BITS-1:0] dterm_ff, dterm_in;
   logic signed [SPEED_BITS-1:0] speed_ff;

   // Three independent multiplies; the I product just fits its width
   always_comb begin
      pterm_in = PTERM_BITS'($signed({1'b0, gains.p_gain}) * err);
      iterm_in = ITERM_BITS'($signed({1'b0, gains.i_gain}) * err_sum);
      dterm_in = DTERM_BITS'($signed({1'b0, gains.d_gain}) * err_diff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pterm_ff <= pterm_in;
         iterm_ff <= iterm_in;
         dterm_ff <= dterm_in;
         speed_ff <= speed;
      end
   end

   assign pterm     = pterm_ff;
   assign iterm     = iterm_ff;
   assign dterm     = dterm_ff;
   assign speed_out = speed_ff;

endmodule

### src/lfps_out_stage.sv
// Term sum, scaling, clamp and negation into the result register.
module lfps_out_stage (
   input  logic                                    clock,
   input  logic                                    enable,
   input  logic signed [lfps_pkg::PTERM_BITS-1:0]  pterm,
   input  logic signed [lfps_pkg::ITERM_BITS-1:0]  iterm,
   input  logic signed [lfps_pkg::DTERM_BITS-1:0]  dterm,
   input  logic signed [lfps_pkg::SPEED_BITS-1:0]  speed,
   output logic signed [lfps_pkg::TURN_BITS-1:0]   turn,
   output logic signed [lfps_pkg::SPEED_BITS-1:0]  speed_out
);
   import lfps_pkg::*;

   logic signed [TOTAL_BITS-1:0] total;
   logic        [TOTAL_BITS-1:0] mag;
   logic        [QUOT_BITS-1:0]  quot;
   logic        [TURN_BITS-1:0]  clamped;
   logic signed [TURN_BITS-1:0]  turn_ff, turn_in;
   logic signed [SPEED_BITS-1:0] speed_ff;

   // Magnitude is truncated toward zero, clamped, then the sign is flipped
   always_comb begin
      total = TOTAL_BITS'(pterm) + TOTAL_BITS'(iterm) + TOTAL_BITS'(dterm);
      mag   = total[TOTAL_BITS-1] ? TOTAL_BITS'(-total) : TOTAL_BITS'(total);
      quot  = mag[TOTAL_BITS-1:GAIN_FRAC_BITS];
      if (quot > QUOT_BITS'(TURN_LIMIT)) begin
         clamped = TURN_LIMIT;
      end else begin
         clamped = quot[TURN_BITS-1:0];
      end
      if (!total[TOTAL_BITS-1] && (total != '0)) begin
         turn_in = -$signed(clamped);
      end else begin
         turn_in = $signed(clamped);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         turn_ff  <= turn_in;
         speed_ff <= speed;
      end
   end

   assign turn      = turn_ff;
   assign speed_out = speed_ff;

endmodule

### src/line_follow_pid_steering_core.sv
// Line-follow PID steering core: register file, pipeline control and stage wiring.
// An accepted transaction passes the error, multiply and output stage registers to rsp_.
// Throughput: one transaction per cycle unless stalled; error sum and previous error
// update on accept, so back-to-back samples see each other's state with no bubble.
// Reset: synchronous active high; clears the loop state, pipeline valids and restores
// the register reset values.
module line_follow_pid_steering_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [lfps_pkg::SAMPLE_BITS-1:0]        req_light_sample,
   input  logic signed [lfps_pkg::SPEED_BITS-1:0]  req_travel_speed,
   input  logic                                    req_clear_state,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [lfps_pkg::TURN_BITS-1:0]   rsp_turn_command,
   output logic signed [lfps_pkg::SPEED_BITS-1:0]  rsp_forward_command,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [lfps_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [lfps_pkg::GAIN_BITS-1:0]          csr_wdata
);
   import lfps_pkg::*;

   logic [SAMPLE_BITS-1:0] gray_ff;
   gains_type              gains_ff;
   logic                   v1_ff, v2_ff, v3_ff;
   logic                   en1, en2, en3, accept;

   logic signed [ERR_BITS-1:0]   s1_err;
   logic signed [SUM_BITS-1:0]   s1_sum;
   logic signed [DIFF_BITS-1:0]  s1_diff;
   logic signed [SPEED_BITS-1:0] s1_speed, s2_speed;
   logic signed [PTERM_BITS-1:0] s2_pterm;
   logic signed [ITERM_BITS-1:0] s2_iterm;
   logic signed [DTERM_BITS-1:0] s2_dterm;

   // Register file; writes are always taken, unused gray bits dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gray_ff         <= GRAY_LEVEL_RST;
         gains_ff.p_gain <= P_GAIN_RST;
         gains_ff.i_gain <= I_GAIN_RST;
         gains_ff.d_gain <= D_GAIN_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GRAY_LEVEL: gray_ff         <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_P_GAIN:     gains_ff.p_gain <= csr_wdata;
            CSR_I_GAIN:     gains_ff.i_gain <= csr_wdata;
            CSR_D_GAIN:     gains_ff.d_gain <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline advance: a stage loads when it is empty or the next one loads
   always_comb begin
      en3    = !v3_ff || !rsp_stall;
      en2    = !v2_ff || en3;
      en1    = !v1_ff || en2;
      accept = req_valid && en1;
   end

   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= accept;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   lfps_err_stage u_err (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .gray_level    (gray_ff),
      .light_sample  (req_light_sample),
      .travel_speed  (req_travel_speed),
      .clear_state   (req_clear_state),
      .err           (s1_err),
      .err_sum       (s1_sum),
      .err_diff      (s1_diff),
      .speed         (s1_speed)
   );

   lfps_mult_stage u_mult (
      .clock     (clock),
      .enable    (en2),
      .gains     (gains_ff),
      .err       (s1_err),
      .err_sum   (s1_sum),
      .err_diff  (s1_diff),
      .speed     (s1_speed),
      .pterm     (s2_pterm),
      .iterm     (s2_iterm),
      .dterm     (s2_dterm),
      .speed_out (s2_speed)
   );

   lfps_out_stage u_out (
      .clock     (clock),
      .enable    (en3),
      .pterm     (s2_pterm),
      .iterm     (s2_iterm),
      .dterm     (s2_dterm),
      .speed     (s2_speed),
      .turn      (rsp_turn_command),
      .speed_out (rsp_forward_command)
   );

   assign rsp_valid = v3_ff;

endmodule
